@@ rtl/rtp_header_parser_top_macros.svh @@
// Assertion macros used by the RTP header parser core.
`ifndef RTP_HEADER_PARSER_TOP_MACROS_SVH
`define RTP_HEADER_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RHP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RHP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rhp_pkg.sv @@
// Package with the types and constants of the RTP header parser.
`default_nettype none
package rhp_pkg;

	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 144;
	localparam int CMP_W       = 17;
	localparam int HLEN_W      = 19;

	localparam logic [CMP_W-1:0] HDR_BYTES = 17'd12;
	localparam logic [7:0]       P_BIT     = 8'h20;
	localparam logic [7:0]       X_BIT     = 8'h10;
	localparam logic [7:0]       M_BIT     = 8'h80;
	localparam logic [7:0]       PT_MASK   = 8'h7F;

	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} byte_s1_t;

	typedef struct packed {
		logic              kind;
		logic              status;
		logic [1:0]        version;
		logic              marker;
		logic [6:0]        payload_type;
		logic [15:0]       sequence_number;
		logic [31:0]       time_stamp;
		logic [31:0]       identifier;
		logic [3:0]        csrc_count;
		logic [15:0]       extension_tag;
		logic [HLEN_W-1:0] header_length;
		logic [7:0]        padding_length;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/rhp_in_reg.sv @@
// Input register stage that holds one accepted packet byte.
`default_nettype none
module rhp_in_reg
	import rhp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [TDATA_IN_W-1:0] s_tdata,
	input  wire logic                  s_tlast,
	input  wire logic                  advance,
	output byte_s1_t                   byte_s1
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign byte_s1 = '{valid: valid_s1, data: data_s1, last: last_s1};

endmodule
`default_nettype wire

@@ rtl/rhp_parse_core.sv @@
// Header field capture, CSRC assembly and packet summary logic.
`default_nettype none
`include "rtp_header_parser_top_macros.svh"
module rhp_parse_core
	import rhp_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = 65535
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire byte_s1_t byte_s1,
	input  wire logic     advance,
	output logic          res_valid,
	output result_t       res
);

	localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_PACKET_BYTES);

	logic [IDX_W-1:0] byte_idx_q, byte_idx_d;
	logic [7:0]       fhb_q, fhb_d;
	logic [7:0]       shb_q, shb_d;
	logic [15:0]      seq_q, seq_d;
	logic [31:0]      ts_q, ts_d;
	logic [31:0]      ssrc_q, ssrc_d;
	logic [31:0]      word_q, word_d;
	logic [15:0]      ext_tag_q, ext_tag_d;
	logic [15:0]      ext_words_q, ext_words_d;

	logic             fire;
	logic [7:0]       b;
	logic [CMP_W-1:0] pos;
	logic [CMP_W-1:0] csrc_end;
	logic [CMP_W-1:0] csrc_off;
	logic [CMP_W-1:0] ext_off;
	logic [CMP_W-1:0] len;
	logic [CMP_W-1:0] need;
	logic [3:0]       cc_new;
	logic             x_new;
	logic             entry;
	logic [HLEN_W-1:0] hlen;
	logic             entry_out;
	logic             entry_ok;
	logic             short_out;
	logic             short_ok;

	assign fire = byte_s1.valid && advance;
	assign b    = byte_s1.data;
	assign pos  = CMP_W'(byte_idx_q);
	assign csrc_end = HDR_BYTES + {{(CMP_W-6){1'b0}}, fhb_q[3:0], 2'b00};
	assign csrc_off = pos - HDR_BYTES;
	assign ext_off  = pos - csrc_end;

	always_comb begin
		byte_idx_d  = byte_idx_q;
		fhb_d       = fhb_q;
		shb_d       = shb_q;
		seq_d       = seq_q;
		ts_d        = ts_q;
		ssrc_d      = ssrc_q;
		word_d      = word_q;
		ext_tag_d   = ext_tag_q;
		ext_words_d = ext_words_q;
		entry       = 1'b0;
		if (byte_idx_q < IDX_MAX) begin
			byte_idx_d = byte_idx_q + 1'b1;
			if (pos == '0) begin
				fhb_d = b;
			end else if (pos == CMP_W'(1)) begin
				shb_d = b;
			end else if (pos < CMP_W'(4)) begin
				seq_d = {seq_q[7:0], b};
			end else if (pos < CMP_W'(8)) begin
				ts_d = {ts_q[23:0], b};
			end else if (pos < HDR_BYTES) begin
				ssrc_d = {ssrc_q[23:0], b};
			end else if (pos < csrc_end) begin
				word_d = {word_q[23:0], b};
				entry  = (csrc_off[1:0] == 2'b11) && !byte_s1.last;
			end else if (((fhb_q & X_BIT) != '0) && (pos < csrc_end + CMP_W'(4))) begin
				if (ext_off < CMP_W'(2)) begin
					ext_tag_d = {ext_tag_q[7:0], b};
				end else begin
					ext_words_d = {ext_words_q[7:0], b};
				end
			end
		end
	end

	assign cc_new = fhb_d[3:0];
	assign x_new  = (fhb_d & X_BIT) != '0;
	assign len    = CMP_W'(byte_idx_d);
	assign need   = HDR_BYTES + {{(CMP_W-6){1'b0}}, cc_new, 2'b00}
		+ (x_new ? CMP_W'(4) : '0);
	assign hlen   = HLEN_W'(12) + HLEN_W'({cc_new, 2'b00})
		+ (x_new ? (HLEN_W'(4) + HLEN_W'({ext_words_d, 2'b00})) : '0);

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (byte_s1.valid) begin
			if (byte_s1.last) begin
				res_valid = 1'b1;
				res.kind  = KIND_SUMMARY;
				if (len < need) begin
					res.status = STATUS_SHORT;
				end else begin
					res.status          = STATUS_OK;
					res.version         = fhb_d[7:6];
					res.marker          = (shb_d & M_BIT) != '0;
					res.payload_type    = shb_d[6:0] & PT_MASK[6:0];
					res.sequence_number = seq_d;
					res.time_stamp      = ts_d;
					res.identifier      = ssrc_d;
					res.csrc_count      = cc_new;
					res.extension_tag   = x_new ? ext_tag_d : '0;
					res.header_length   = hlen;
					res.padding_length  = ((fhb_d & P_BIT) != '0) ? b : '0;
				end
			end else if (entry) begin
				res_valid      = 1'b1;
				res.kind       = KIND_ENTRY;
				res.identifier = word_d;
				res.csrc_count = csrc_off[5:2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q  <= '0;
			fhb_q       <= '0;
			shb_q       <= '0;
			seq_q       <= '0;
			ts_q        <= '0;
			ssrc_q      <= '0;
			word_q      <= '0;
			ext_tag_q   <= '0;
			ext_words_q <= '0;
		end else if (fire) begin
			if (byte_s1.last) begin
				byte_idx_q  <= '0;
				fhb_q       <= '0;
				shb_q       <= '0;
				seq_q       <= '0;
				ts_q        <= '0;
				ssrc_q      <= '0;
				word_q      <= '0;
				ext_tag_q   <= '0;
				ext_words_q <= '0;
			end else begin
				byte_idx_q  <= byte_idx_d;
				fhb_q       <= fhb_d;
				shb_q       <= shb_d;
				seq_q       <= seq_d;
				ts_q        <= ts_d;
				ssrc_q      <= ssrc_d;
				word_q      <= word_d;
				ext_tag_q   <= ext_tag_d;
				ext_words_q <= ext_words_d;
			end
		end
	end

	assign entry_out = res_valid && (res.kind == KIND_ENTRY);
	assign entry_ok  = !byte_s1.last && (res.csrc_count < fhb_q[3:0]);
	assign short_out = res_valid && (res.status == STATUS_SHORT);
	assign short_ok  = (res.header_length == '0) && (res.identifier == '0);

	`RHP_ASSERT_NEXT(a_clear_after_last, fire && byte_s1.last, byte_idx_q == '0, "byte index kept")
	`RHP_ASSERT_SAME(a_idx_bound, 1'b1, byte_idx_q <= IDX_MAX, "byte index beyond packet limit")
	`RHP_ASSERT_SAME(a_entry_not_last, entry_out, entry_ok, "CSRC entry out of place")
	`RHP_ASSERT_SAME(a_short_zero, short_out, short_ok, "short packet summary carries fields")

endmodule
`default_nettype wire

@@ rtl/rhp_out_reg.sv @@
// Result register that drives the master-side stream.
`default_nettype none
module rhp_out_reg
	import rhp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   res_load,
	input  wire logic                   res_valid,
	input  wire result_t                res,
	output logic                        advance,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [TDATA_OUT_W-1:0]      m_tdata,
	output logic                        m_tuser
);

	logic    valid_q;
	result_t res_q;

	assign advance = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_load && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_load && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {6'b0, res_q.padding_length, res_q.header_length, res_q.extension_tag,
		res_q.csrc_count, res_q.identifier, res_q.time_stamp, res_q.sequence_number,
		res_q.payload_type, res_q.marker, res_q.version, res_q.status};

endmodule
`default_nettype wire

@@ rtl/rtp_header_parser_top.sv @@
// A byte's result, if any, is registered in the result register and offered from there.
// Throughput: one byte per cycle unless a result is held by m_tready; the input and result
// registers let one more byte enter while a finished result waits on the master side.
// A byte yields at most one result: a CSRC entry or, on the last byte, a summary.
// Reset is asynchronous and active low; it empties both stages and clears the header state.
`default_nettype none
module rtp_header_parser_top
	import rhp_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = 65535
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// data_byte[7:0]
	input  wire logic [TDATA_IN_W-1:0]  s_tdata,
	input  wire logic                   s_tlast,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// status[0], version[2:1], marker[3], payload_type[10:4],
	// sequence_number[26:11], time_stamp[58:27], identifier[90:59],
	// csrc_count[94:91], extension_tag[110:95], header_length[129:111],
	// padding_length[137:130], zero fill[143:138]
	output logic [TDATA_OUT_W-1:0]      m_tdata,
	// kind[0]
	output logic                        m_tuser
);

	byte_s1_t byte_s1;
	logic     advance;
	logic     res_valid;
	result_t  res;

	rhp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.byte_s1  (byte_s1)
	);

	rhp_parse_core #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_parse_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_s1   (byte_s1),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	rhp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (byte_s1.valid),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the RTP header parser: directed and random packets in, entries and summaries checked.
`timescale 1ns / 1ps
module tb_top;
	import rhp_pkg::*;

	localparam int PKT_LIMIT      = 100;
	localparam int BYTE_TARGET    = 1800;
	localparam int CALM_TAIL      = 250;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 10;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} packet_byte_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   m_tuser;

	packet_byte_t bytes_to_send[$];
	result_t      expected_results[$];
	packet_byte_t next_byte;
	result_t      seen_result;
	result_t      wanted_result;
	int           send_gap     = 0;
	int           take_gap     = 0;
	int           fault_count  = 0;
	int           quiet_cycles = 0;

	// Parser state mirrored by the bench.
	int          pkt_bytes_seen = 0;
	logic [7:0]  hdr_byte0      = '0;
	logic [7:0]  hdr_byte1      = '0;
	logic [15:0] seq_acc        = '0;
	logic [31:0] stamp_acc      = '0;
	logic [31:0] ssrc_acc       = '0;
	logic [31:0] csrc_acc       = '0;
	logic [15:0] ext_tag_acc    = '0;
	logic [15:0] ext_words_acc  = '0;

	rtp_header_parser_top #(
		.MAX_PACKET_BYTES(PKT_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #4 clk = ~clk;

	function automatic void predict_byte(logic [7:0] b, logic last);
		result_t res;
		int      cc_w;
		int      csrc_end;
		int      need;
		int      hlen;
		logic    x_on;
		logic    entry;
		res = '0;
		entry = 1'b0;
		if (pkt_bytes_seen < PKT_LIMIT) begin
			cc_w = int'(hdr_byte0[3:0]);
			csrc_end = int'(HDR_BYTES) + 4 * cc_w;
			if (pkt_bytes_seen == 0) begin
				hdr_byte0 = b;
			end else if (pkt_bytes_seen == 1) begin
				hdr_byte1 = b;
			end else if (pkt_bytes_seen < 4) begin
				seq_acc = {seq_acc[7:0], b};
			end else if (pkt_bytes_seen < 8) begin
				stamp_acc = {stamp_acc[23:0], b};
			end else if (pkt_bytes_seen < int'(HDR_BYTES)) begin
				ssrc_acc = {ssrc_acc[23:0], b};
			end else if (pkt_bytes_seen < csrc_end) begin
				csrc_acc = {csrc_acc[23:0], b};
				if ((pkt_bytes_seen - int'(HDR_BYTES)) % 4 == 3 && !last) begin
					res.kind = KIND_ENTRY;
					res.identifier = csrc_acc;
					res.csrc_count = 4'((pkt_bytes_seen - int'(HDR_BYTES)) / 4);
					entry = 1'b1;
				end
			end else if ((hdr_byte0 & X_BIT) != 0 && pkt_bytes_seen < csrc_end + 4) begin
				if (pkt_bytes_seen - csrc_end < 2)
					ext_tag_acc = {ext_tag_acc[7:0], b};
				else
					ext_words_acc = {ext_words_acc[7:0], b};
			end
			pkt_bytes_seen++;
		end
		if (last) begin
			cc_w = int'(hdr_byte0[3:0]);
			x_on = (hdr_byte0 & X_BIT) != 0;
			need = int'(HDR_BYTES) + 4 * cc_w + (x_on ? 4 : 0);
			res = '0;
			res.kind = KIND_SUMMARY;
			if (pkt_bytes_seen < need) begin
				res.status = STATUS_SHORT;
			end else begin
				hlen = int'(HDR_BYTES) + 4 * cc_w;
				if (x_on)
					hlen += 4 + 4 * int'(ext_words_acc);
				res.status = STATUS_OK;
				res.version = hdr_byte0[7:6];
				res.marker = (hdr_byte1 & M_BIT) != 0;
				res.payload_type = 7'(hdr_byte1 & PT_MASK);
				res.sequence_number = seq_acc;
				res.time_stamp = stamp_acc;
				res.identifier = ssrc_acc;
				res.csrc_count = hdr_byte0[3:0];
				res.extension_tag = x_on ? ext_tag_acc : 16'h0000;
				res.header_length = HLEN_W'(hlen);
				res.padding_length = ((hdr_byte0 & P_BIT) != 0) ? b : 8'h00;
			end
			expected_results.push_back(res);
			pkt_bytes_seen = 0;
			hdr_byte0 = '0;
			hdr_byte1 = '0;
			seq_acc = '0;
			stamp_acc = '0;
			ssrc_acc = '0;
			csrc_acc = '0;
			ext_tag_acc = '0;
			ext_words_acc = '0;
		end else if (entry) begin
			expected_results.push_back(res);
		end
	endfunction

	function automatic result_t unpack_result(logic kind_bit, logic [TDATA_OUT_W-1:0] d);
		result_t r;
		r.kind = kind_bit;
		{r.padding_length, r.header_length, r.extension_tag, r.csrc_count, r.identifier,
			r.time_stamp, r.sequence_number, r.payload_type, r.marker, r.version,
			r.status} = d[137:0];
		return r;
	endfunction

	task automatic push_packet(input logic [7:0] body[$]);
		foreach (body[i])
			bytes_to_send.push_back('{data: body[i], last: (i == body.size() - 1)});
	endtask

	task automatic add_random_packet();
		logic [7:0]  body[$];
		int unsigned pick;
		int unsigned cc;
		int unsigned need;
		int unsigned cut;
		int unsigned target_len;
		logic        x_flag;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			repeat ($urandom_range(1, 40)) body.push_back(8'($urandom()));
		end else begin
			cc = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
			x_flag = 1'($urandom_range(0, 1));
			body.push_back({(($urandom_range(0, 3) == 0) ? 2'($urandom()) : 2'd2),
				1'($urandom()), x_flag, 4'(cc)});
			repeat (11 + 4 * cc) body.push_back(8'($urandom()));
			if (x_flag) begin
				body.push_back(8'($urandom()));
				body.push_back(8'($urandom()));
				if ($urandom_range(0, 1)) begin
					body.push_back(8'h00);
					body.push_back(8'($urandom_range(0, 3)));
				end else begin
					body.push_back(8'($urandom()));
					body.push_back(8'($urandom()));
				end
			end
			if ($urandom_range(0, 3) != 0)
				repeat ($urandom_range(1, 20)) body.push_back(8'($urandom()));
			need = 12 + 4 * cc + (x_flag ? 4 : 0);
			if (pick < 18) begin
				cut = $urandom_range(1, need - 1);
				while (body.size() > cut) void'(body.pop_back());
			end else if (pick < 22) begin
				target_len = PKT_LIMIT + $urandom_range(1, 30);
				while (body.size() < target_len) body.push_back(8'($urandom()));
			end
		end
		push_packet(body);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (bytes_to_send.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (bytes_to_send.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 16);
					s_tvalid <= 1'b0;
				end else begin
					next_byte = bytes_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_byte.data;
					s_tlast <= next_byte.last;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_result = unpack_result(m_tuser, m_tdata);
				if (expected_results.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("Unexpected result transfer: %p", seen_result);
				end else begin
					wanted_result = expected_results.pop_front();
					if (seen_result !== wanted_result) begin
						fault_count++;
						if (fault_count <= 10)
							$display("Mismatch: expected %p, actual %p", wanted_result,
								seen_result);
					end
				end
			end
			if (take_gap > 0) begin
				take_gap <= take_gap - 1;
				m_tready <= 1'b0;
			end else if (bytes_to_send.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
				take_gap <= $urandom_range(0, 16);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [7:0] body[$];
		// A one-byte packet is too short for the header.
		body = {8'hFF};
		push_packet(body);
		// All-ones field values after the first byte, with padding taken from the final byte.
		body = {8'hA0};
		repeat (11) body.push_back(8'hFF);
		push_packet(body);
		// Minimal header with every field zero.
		body = {};
		repeat (12) body.push_back(8'h00);
		push_packet(body);
		while (bytes_to_send.size() < BYTE_TARGET)
			add_random_packet();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (bytes_to_send.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/rhp_pkg.sv
rtl/rhp_in_reg.sv
rtl/rhp_parse_core.sv
rtl/rhp_out_reg.sv
rtl/rtp_header_parser_top.sv
bench/tb_top.sv
